// ===== hdl/tid_pkg.sv =====
// Shared types, register codes and helper functions for the timer and
// interrupt dispatch block. No dependencies.
package tid_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_COUNT_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_TIMER_PERIOD     = 2'd1;
    localparam logic [1:0] CFG_TIMER_MODULO     = 2'd2;
    localparam logic [1:0] CFG_INTERRUPT_ENABLE = 2'd3;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned IRQ_N       = 5;

    // timer period limits and the reset value of the period register
    localparam logic [10:0] PERIOD_MIN   = 11'd16;
    localparam logic [10:0] PERIOD_MAX   = 11'd1024;

    // the timer source sits at bit 2 of the request flags
    localparam int unsigned TIMER_BIT = 2;

    // first handler address, handlers are 8 bytes apart
    localparam logic [6:0] VECTOR_BASE = 7'h40;

    typedef struct packed {
        logic        count_enable;
        logic [10:0] timer_period;
        logic [7:0]  timer_modulo;
        logic [4:0]  interrupt_enable;
    } t_cfg;

    typedef struct packed {
        logic [4:0] pending;
        logic       take;
        logic [6:0] vector;
        logic       wake;
    } t_irq_res;

    // one timer increment: returns {overflow, new count}
    function automatic logic [8:0] tid_tick(input logic [7:0] cnt, input logic [7:0] modulo);
        logic [8:0] sum;
        begin
            sum = {1'b0, cnt} + 9'd1;
            if (sum[8]) begin
                tid_tick = {1'b1, modulo};
            end else begin
                tid_tick = {1'b0, sum[7:0]};
            end
        end
    endfunction

    // handler address for a source index
    function automatic logic [6:0] tid_vector(input logic [2:0] idx);
        begin
            tid_vector = VECTOR_BASE + {1'b0, idx, 3'b000};
        end
    endfunction

endpackage

// ===== hdl/timer_and_interrupt_dispatch.sv =====
// Top level: configuration registers, input register, result register.
// Depends on tid_pkg, tid_timer, tid_irq.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | in        | i_in_valid / o_in_stall    | cycles, requests, ime, pc
//  out     | out       | o_out_valid / i_out_stall  | divider, timer, flags, dispatch
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A request is held in the input register, then its result is computed in
// one pass and loaded into the result register. One request per cycle is
// sustained while the output does not stall, set by the single state update.
// Reset clears all counters and request flags, and restores register defaults.
// A stall on the output holds the result; the input register still takes
// one more request before the input stalls. Config is always ready.
module timer_and_interrupt_dispatch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    // request input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [4:0]  i_step_cycles,
    input  logic [4:0]  i_external_requests,
    input  logic        i_master_enable,
    input  logic [15:0] i_program_counter,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_divider_value,
    output logic [7:0]  o_timer_value,
    output logic [4:0]  o_pending_flags,
    output logic        o_take_interrupt,
    output logic [6:0]  o_vector_address,
    output logic [15:0] o_return_address,
    output logic        o_wake
);

    tid_pkg::t_cfg     r_cfg;
    tid_pkg::t_irq_res irq_res;

    logic        r_s1_valid;
    logic [4:0]  r_s1_cycles;
    logic [4:0]  r_s1_reqs;
    logic        r_s1_ime;
    logic [15:0] r_s1_pc;

    logic        r_out_valid;
    logic [7:0]  r_div;
    logic [7:0]  r_tima;
    logic [4:0]  r_pending;
    logic        r_take;
    logic [6:0]  r_vector;
    logic [15:0] r_ret;
    logic        r_wake;

    logic        out_free;
    logic        s1_move;
    logic        in_accept;
    logic [7:0]  div_next;
    logic [7:0]  tima_next;
    logic        timer_irq;

    // pipeline flow control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_enable     <= 1'b0;
            r_cfg.timer_period     <= tid_pkg::PERIOD_MAX;
            r_cfg.timer_modulo     <= '0;
            r_cfg.interrupt_enable <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tid_pkg::CFG_COUNT_ENABLE:     r_cfg.count_enable     <= i_cfg_data[0];
                tid_pkg::CFG_TIMER_PERIOD:     r_cfg.timer_period     <= i_cfg_data;
                tid_pkg::CFG_TIMER_MODULO:     r_cfg.timer_modulo     <= i_cfg_data[7:0];
                tid_pkg::CFG_INTERRUPT_ENABLE: r_cfg.interrupt_enable <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cycles <= i_step_cycles;
            r_s1_reqs   <= i_external_requests;
            r_s1_ime    <= i_master_enable;
            r_s1_pc     <= i_program_counter;
        end
    end

    tid_timer u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_move),
        .i_cycles    (r_s1_cycles),
        .i_cfg       (r_cfg),
        .o_div_next  (div_next),
        .o_tima_next (tima_next),
        .o_timer_irq (timer_irq)
    );

    tid_irq u_irq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_move),
        .i_reqs      (r_s1_reqs),
        .i_timer_irq (timer_irq),
        .i_ime       (r_s1_ime),
        .i_ie        (r_cfg.interrupt_enable),
        .o_res       (irq_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_div     <= div_next;
            r_tima    <= tima_next;
            r_pending <= irq_res.pending;
            r_take    <= irq_res.take;
            r_vector  <= irq_res.vector;
            r_ret     <= irq_res.take ? r_s1_pc : 16'd0;
            r_wake    <= irq_res.wake;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_divider_value  = r_div;
    assign o_timer_value    = r_tima;
    assign o_pending_flags  = r_pending;
    assign o_take_interrupt = r_take;
    assign o_vector_address = r_vector;
    assign o_return_address = r_ret;
    assign o_wake           = r_wake;

endmodule

// ===== hdl/tid_timer.sv =====
// Free-running divider and programmable timer counter with prescalers.
// Depends on tid_pkg.
module tid_timer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [4:0]        i_cycles,
    input  tid_pkg::t_cfg     i_cfg,
    output logic [7:0]        o_div_next,
    output logic [7:0]        o_tima_next,
    output logic              o_timer_irq
);

    logic [7:0]  r_div_pre, n_div_pre;
    logic [7:0]  r_div_cnt, n_div_cnt;
    logic [9:0]  r_tim_pre, n_tim_pre;
    logic [7:0]  r_tim_cnt, n_tim_cnt;

    logic [8:0]  div_sum;
    logic [10:0] period;
    logic [10:0] tsum, t1, t2;
    logic        ge1, ge2;
    logic [8:0]  tick1, tick2;

    // divider: carry out of the 8-bit prescaler advances the count
    always_comb begin
        div_sum   = {1'b0, r_div_pre} + {4'b0, i_cycles};
        n_div_pre = div_sum[7:0];
        n_div_cnt = r_div_cnt + {7'b0, div_sum[8]};
    end

    // clamp period into its legal range
    always_comb begin
        if (i_cfg.timer_period < tid_pkg::PERIOD_MIN) begin
            period = tid_pkg::PERIOD_MIN;
        end else if (i_cfg.timer_period > tid_pkg::PERIOD_MAX) begin
            period = tid_pkg::PERIOD_MAX;
        end else begin
            period = i_cfg.timer_period;
        end
    end

    // timer: up to two increments per step
    always_comb begin
        tsum  = {1'b0, r_tim_pre} + {6'b0, i_cycles};
        ge1   = (tsum >= period);
        t1    = ge1 ? (tsum - period) : tsum;
        ge2   = ge1 && (t1 >= period);
        t2    = ge2 ? (t1 - period) : t1;
        tick1 = ge1 ? tid_pkg::tid_tick(r_tim_cnt, i_cfg.timer_modulo) : {1'b0, r_tim_cnt};
        tick2 = ge2 ? tid_pkg::tid_tick(tick1[7:0], i_cfg.timer_modulo) : {1'b0, tick1[7:0]};
        if (i_cfg.count_enable) begin
            n_tim_pre   = t2[9:0];
            n_tim_cnt   = tick2[7:0];
            o_timer_irq = tick1[8] | tick2[8];
        end else begin
            n_tim_pre   = r_tim_pre;
            n_tim_cnt   = r_tim_cnt;
            o_timer_irq = 1'b0;
        end
    end

    assign o_div_next  = n_div_cnt;
    assign o_tima_next = n_tim_cnt;

    // state update once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_pre <= '0;
            r_div_cnt <= '0;
            r_tim_pre <= '0;
            r_tim_cnt <= '0;
        end else if (i_step) begin
            r_div_pre <= n_div_pre;
            r_div_cnt <= n_div_cnt;
            r_tim_pre <= n_tim_pre;
            r_tim_cnt <= n_tim_cnt;
        end
    end

endmodule

// ===== hdl/tid_irq.sv =====
// Interrupt request flags and fixed-priority dispatch.
// Depends on tid_pkg.
module tid_irq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [4:0]          i_reqs,
    input  logic                i_timer_irq,
    input  logic                i_ime,
    input  logic [4:0]          i_ie,
    output tid_pkg::t_irq_res   o_res
);

    logic [4:0] r_flags, n_flags;
    logic [4:0] merged;
    logic [4:0] ready;
    logic [4:0] sel_mask;
    logic [2:0] sel_idx;
    logic       any_ready;

    // merge new requests and the timer overflow
    always_comb begin
        merged = r_flags | i_reqs;
        merged[tid_pkg::TIMER_BIT] = merged[tid_pkg::TIMER_BIT] | i_timer_irq;
        ready  = i_ime ? (merged & i_ie) : 5'b0;
    end

    // lowest set bit wins
    always_comb begin
        sel_idx  = '0;
        sel_mask = '0;
        for (int i = tid_pkg::IRQ_N - 1; i >= 0; i--) begin
            if (ready[i]) begin
                sel_idx  = 3'(i);
                sel_mask = 5'b00001 << i;
            end
        end
        any_ready = |ready;
        n_flags   = merged & ~sel_mask;
    end

    always_comb begin
        o_res.pending = n_flags;
        o_res.take    = any_ready;
        o_res.vector  = any_ready ? tid_pkg::tid_vector(sel_idx) : 7'd0;
        o_res.wake    = |merged;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_step) begin
            r_flags <= n_flags;
        end
    end

endmodule

// ===== hdl/tid_checker.sv =====
// Port-level checks for timer_and_interrupt_dispatch, bound to the top level.
// Depends on timer_and_interrupt_dispatch ports only.
module tid_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_take_interrupt,
    input logic        o_wake,
    input logic [6:0]  o_vector_address,
    input logic [15:0] o_return_address
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // a stalled result stays presented
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

    // a dispatch needs a pending flag and a handler address
    a_take_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_take_interrupt) |-> (o_wake && (o_vector_address != 7'd0)))
        else $error("dispatch without vector or wake");

    // no dispatch means zero address fields
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_take_interrupt) |->
            ((o_vector_address == 7'd0) && (o_return_address == 16'd0)))
        else $error("address fields set without dispatch");

endmodule

bind timer_and_interrupt_dispatch tid_assert u_tid_assert (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_take_interrupt (o_take_interrupt),
    .o_wake           (o_wake),
    .o_vector_address (o_vector_address),
    .o_return_address (o_return_address)
);
